[rtl/dahq_pkg.sv]
// dahq_pkg: shared types, codes and default sizes for the d-ary min-heap queue.
// Used by the heap engine, the top level and the port checker.
package dahq_pkg;

  // Default heap shape
  localparam int unsigned ARITY_DEF    = 3;
  localparam int unsigned CAPACITY_DEF = 256;

  // Fixed field widths
  localparam int unsigned KEY_W  = 32;
  localparam int unsigned TAG_W  = 16;
  localparam int unsigned FUNC_W = 2;
  localparam int unsigned STAT_W = 2;
  localparam int unsigned OCC_W  = 9;

  // Operation codes
  localparam logic [FUNC_W-1:0] FUNC_ENQ  = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_DEQ  = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_PEEK = 2'd2;

  // Status codes
  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_UNDER = 2'd1;
  localparam logic [STAT_W-1:0] ST_OVER  = 2'd2;

  // One heap entry
  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [TAG_W-1:0] tag;
  } entry_t;

  // One request word
  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [KEY_W-1:0]  key;
    logic [TAG_W-1:0]  tag;
  } req_t;

  // One result word
  typedef struct packed {
    logic [KEY_W-1:0]  key;
    logic [TAG_W-1:0]  tag;
    logic              valid;
    logic [STAT_W-1:0] status;
    logic [OCC_W-1:0]  occupancy;
    logic              is_empty;
  } result_t;

  // Engine to top level: status plus finished result
  typedef struct packed {
    logic    idle;
    logic    done;
    result_t res;
  } eng_rsp_t;

endpackage

[rtl/dahq_engine.sv]
// dahq_engine: heap storage and the sequencer that runs enqueue, dequeue and peek.
// Key comparators walk the heap a level at a time. Depends on dahq_pkg.
module dahq_engine
  import dahq_pkg::*;
#(
  parameter int unsigned ARITY    = ARITY_DEF,
  parameter int unsigned CAPACITY = CAPACITY_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  input  req_t     req,
  output eng_rsp_t rsp
);

  localparam int unsigned AW  = $clog2(CAPACITY);
  localparam int unsigned CW  = $clog2(CAPACITY + 1);
  localparam int unsigned IW  = $clog2(ARITY);
  localparam int unsigned CBW = AW + $clog2(ARITY) + 1;
  // Parent index by reciprocal multiply: exact for all AW-bit positions
  localparam int unsigned PS  = AW + $clog2(ARITY);
  localparam int unsigned PM  = ((1 << PS) + ARITY - 1) / ARITY;
  localparam int unsigned PW  = AW + PS;

  typedef enum logic [9:0] {
    S_IDLE     = 10'b00_0000_0001,
    S_UP_RD    = 10'b00_0000_0010,
    S_UP_CMP   = 10'b00_0000_0100,
    S_ROOT_GET = 10'b00_0000_1000,
    S_LAST     = 10'b00_0001_0000,
    S_DN_RD    = 10'b00_0010_0000,
    S_DN_CMP   = 10'b00_0100_0000,
    S_DN_DEC   = 10'b00_1000_0000,
    S_DONE     = 10'b01_0000_0000,
    S_SPARE    = 10'b10_0000_0000
  } state_t;

  state_t             state_r, state_nxt;
  logic [CW-1:0]      cnt_r, cnt_nxt;
  logic [AW-1:0]      pos_r, pos_nxt;
  logic [AW-1:0]      par_r, par_nxt;
  logic [CBW-1:0]     base_r, base_nxt;
  logic [IW-1:0]      idx_r, idx_nxt;
  logic [AW-1:0]      best_addr_r, best_addr_nxt;
  entry_t             ent_r, ent_nxt;
  entry_t             best_r, best_nxt;
  logic [FUNC_W-1:0]  func_r, func_nxt;
  logic [KEY_W-1:0]   okey_r, okey_nxt;
  logic [TAG_W-1:0]   otag_r, otag_nxt;
  logic               oval_r, oval_nxt;
  logic [STAT_W-1:0]  ostat_r, ostat_nxt;

  entry_t             mem [CAPACITY];
  entry_t             rdat_r;
  logic               rd_en;
  logic [AW-1:0]      rd_addr;
  logic               wr_en;
  logic [AW-1:0]      wr_addr;
  entry_t             wr_data;

  logic [PW-1:0]      par_prod;
  logic [AW-1:0]      parent;
  logic [CBW-1:0]     child_base;
  logic [CBW-1:0]     cur_addr;
  logic [CBW-1:0]     next_addr;
  logic               take;

  // Derive tree neighbors of the current position
  assign par_prod   = PW'(pos_r - AW'(1)) * PW'(PM);
  assign parent     = par_prod[PS +: AW];
  assign child_base = CBW'(pos_r) * CBW'(ARITY) + CBW'(1);
  assign cur_addr   = base_r + CBW'(idx_r);
  assign next_addr  = cur_addr + CBW'(1);
  assign take       = (idx_r == '0) || (rdat_r.key < best_r.key);

  // Sequence one operation
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    pos_nxt       = pos_r;
    par_nxt       = par_r;
    base_nxt      = base_r;
    idx_nxt       = idx_r;
    best_addr_nxt = best_addr_r;
    ent_nxt       = ent_r;
    best_nxt      = best_r;
    func_nxt      = func_r;
    okey_nxt      = okey_r;
    otag_nxt      = otag_r;
    oval_nxt      = oval_r;
    ostat_nxt     = ostat_r;
    rd_en         = 1'b0;
    rd_addr       = '0;
    wr_en         = 1'b0;
    wr_addr       = pos_r;
    wr_data       = ent_r;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          func_nxt  = req.func;
          ent_nxt   = '{key: req.key, tag: req.tag};
          okey_nxt  = '0;
          otag_nxt  = '0;
          oval_nxt  = 1'b0;
          ostat_nxt = ST_OK;
          state_nxt = S_DONE;
          case (req.func)
            FUNC_ENQ: begin
              if (cnt_r >= CW'(CAPACITY)) begin
                ostat_nxt = ST_OVER;
              end else begin
                pos_nxt   = cnt_r[AW-1:0];
                cnt_nxt   = cnt_r + CW'(1);
                state_nxt = S_UP_RD;
              end
            end
            FUNC_DEQ, FUNC_PEEK: begin
              if (cnt_r == '0) begin
                ostat_nxt = ST_UNDER;
              end else begin
                rd_en     = 1'b1;
                rd_addr   = '0;
                state_nxt = S_ROOT_GET;
              end
            end
            default: begin
              state_nxt = S_DONE;
            end
          endcase
        end
      end
      // Fetch the parent, or settle at the root
      S_UP_RD: begin
        if (pos_r == '0) begin
          wr_en     = 1'b1;
          state_nxt = S_DONE;
        end else begin
          rd_en     = 1'b1;
          rd_addr   = parent;
          par_nxt   = parent;
          state_nxt = S_UP_CMP;
        end
      end
      // Pull a larger parent down, or drop the new entry into the hole
      S_UP_CMP: begin
        wr_en = 1'b1;
        if (rdat_r.key > ent_r.key) begin
          wr_data   = rdat_r;
          pos_nxt   = par_r;
          state_nxt = S_UP_RD;
        end else begin
          state_nxt = S_DONE;
        end
      end
      // Capture the root; on a dequeue that leaves entries, fetch the last entry
      S_ROOT_GET: begin
        okey_nxt = rdat_r.key;
        otag_nxt = rdat_r.tag;
        oval_nxt = 1'b1;
        if (func_r == FUNC_PEEK) begin
          state_nxt = S_DONE;
        end else begin
          cnt_nxt = cnt_r - CW'(1);
          pos_nxt = '0;
          if (cnt_r == CW'(1)) begin
            state_nxt = S_DONE;
          end else begin
            rd_en     = 1'b1;
            rd_addr   = AW'(cnt_r - CW'(1));
            state_nxt = S_LAST;
          end
        end
      end
      S_LAST: begin
        ent_nxt   = rdat_r;
        state_nxt = S_DN_RD;
      end
      // Start the child scan, or settle at a leaf
      S_DN_RD: begin
        if (child_base >= CBW'(cnt_r)) begin
          wr_en     = 1'b1;
          state_nxt = S_DONE;
        end else begin
          rd_en     = 1'b1;
          rd_addr   = child_base[AW-1:0];
          base_nxt  = child_base;
          idx_nxt   = '0;
          state_nxt = S_DN_CMP;
        end
      end
      // Keep the first strictly smallest child; fetch the next one
      S_DN_CMP: begin
        if (take) begin
          best_nxt      = rdat_r;
          best_addr_nxt = cur_addr[AW-1:0];
        end
        if ((idx_r != IW'(ARITY - 1)) && (next_addr < CBW'(cnt_r))) begin
          rd_en   = 1'b1;
          rd_addr = next_addr[AW-1:0];
          idx_nxt = idx_r + IW'(1);
        end else begin
          state_nxt = S_DN_DEC;
        end
      end
      // Lift the smallest child into the hole, or place the moving entry
      S_DN_DEC: begin
        wr_en = 1'b1;
        if (ent_r.key > best_r.key) begin
          wr_data   = best_r;
          pos_nxt   = best_addr_r;
          state_nxt = S_DN_RD;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Hold control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // Hold working payload
  always_ff @(posedge clk) begin
    pos_r       <= pos_nxt;
    par_r       <= par_nxt;
    base_r      <= base_nxt;
    idx_r       <= idx_nxt;
    best_addr_r <= best_addr_nxt;
    ent_r       <= ent_nxt;
    best_r      <= best_nxt;
    func_r      <= func_nxt;
    okey_r      <= okey_nxt;
    otag_r      <= otag_nxt;
    oval_r      <= oval_nxt;
    ostat_r     <= ostat_nxt;
  end

  // Heap storage: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdat_r <= mem[rd_addr];
    end
  end

  assign rsp.idle          = (state_r == S_IDLE);
  assign rsp.done          = (state_r == S_DONE);
  assign rsp.res.key       = okey_r;
  assign rsp.res.tag       = otag_r;
  assign rsp.res.valid     = oval_r;
  assign rsp.res.status    = ostat_r;
  assign rsp.res.occupancy = OCC_W'(cnt_r);
  assign rsp.res.is_empty  = (cnt_r == '0);

endmodule

[rtl/d_ary_min_heap_queue_top.sv]
// d_ary_min_heap_queue_top: stream wrapper with the result register around the heap engine.
// Depends on dahq_pkg and dahq_engine.
//
// Min-priority queue of up to CAPACITY key/tag entries kept as an ARITY-ary heap.
// Input channel (in_*): one word per request; in_tuser carries the operation
// (enqueue, dequeue, peek), in_tdata the key and tag to enqueue.
// Output channel (out_*): exactly one word per request with the returned root,
// a valid flag, a status (ok, underflow on empty, overflow when full) and the
// occupancy after the operation.
// A failed request or the unused code goes straight to the done state; a peek,
// or a dequeue that empties the heap, reads the root and is done; an enqueue
// climbs one level per parent read while the parent is larger; a dequeue moves
// the last entry to the root and sinks it, scanning the children of each level
// in turn (a node with fewer children costs less). One memory read per compare,
// since a single read port does all the reads.
// One request is in the engine at a time; the next is accepted once the engine
// is idle and the output register is empty or being emptied.
// Reset clears the entry count and all control state; storage is not cleared.
// A stalled receiver holds the result word on out_* and blocks new requests.
module d_ary_min_heap_queue_top
  import dahq_pkg::*;
#(
  parameter int unsigned ARITY    = ARITY_DEF,
  parameter int unsigned CAPACITY = CAPACITY_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // [31:0] key, [47:32] tag
  input  logic [1:0]  in_tuser,   // [1:0] func
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,  // [31:0] out_key, [47:32] out_tag,
                                  // [56:48] occupancy, [57] is_empty, [63:58] zero
  output logic [2:0]  out_tuser   // [0] out_valid, [2:1] status
);

  logic     start;
  req_t     req;
  eng_rsp_t rsp;
  logic     out_valid_r;
  result_t  out_res_r;

  // Accept a request word when the engine and the output register are free
  assign in_tready = rsp.idle && (!out_valid_r || out_tready);
  assign start     = in_tvalid && in_tready;
  assign req.func  = in_tuser;
  assign req.key   = in_tdata[31:0];
  assign req.tag   = in_tdata[47:32];

  dahq_engine #(
    .ARITY    (ARITY),
    .CAPACITY (CAPACITY)
  ) u_engine (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .req   (req),
    .rsp   (rsp)
  );

  // Load the result word on completion, drop it when taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (rsp.done) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rsp.done) begin
      out_res_r <= rsp.res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'b0, out_res_r.is_empty, out_res_r.occupancy,
                       out_res_r.tag, out_res_r.key};
  assign out_tuser  = {out_res_r.status, out_res_r.valid};

endmodule

[rtl/dahq_checker.sv]
// dahq_checker: port-level checks on the result channel of the heap queue.
// Bound to d_ary_min_heap_queue_top below; depends on dahq_pkg.
module dahq_checker
  import dahq_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [63:0] out_tdata,
  input logic [2:0]  out_tuser
);

  // A returned entry always comes with an ok status
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> out_tuser[2:1] == ST_OK)
    else $error("entry returned with error status");

  // Underflow only happens on an empty heap
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[2:1] == ST_UNDER |-> out_tdata[57])
    else $error("underflow reported on non-empty heap");

  // No entry returned means key and tag read zero
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[0] |-> out_tdata[47:0] == 48'd0)
    else $error("key or tag nonzero without an entry");

  // A stalled result word holds
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result word changed while stalled");

endmodule

bind d_ary_min_heap_queue_top dahq_checker u_dahq_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

[bench/testbench.sv]
// testbench: self-checking bench for the d-ary min-heap queue top level.
// Depends on dahq_pkg and d_ary_min_heap_queue_top; mirrors the heap in a class
// and checks every result word against it.
module testbench;
  import dahq_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // Unused operation code: the block does nothing and reports ok
  localparam logic [FUNC_W-1:0] FUNC_NOP = 2'd3;
  localparam int unsigned IDLE_LIMIT = 2000;
  localparam int unsigned DRAIN_CYCLES = 60;

  // Mirror of the heap: applies each request and holds the result words it predicts
  class heap_tracker;
    logic [KEY_W-1:0] keys [CAPACITY_DEF];
    logic [TAG_W-1:0] tags [CAPACITY_DEF];
    int unsigned fill;
    result_t predicted_words[$];
    int errors;
    int n_enq, n_deq, n_peek, n_nop, n_over, n_under, peak_fill;

    function void swap_slots(int unsigned a, int unsigned b);
      logic [KEY_W-1:0] k;
      logic [TAG_W-1:0] t;
      k = keys[a];
      t = tags[a];
      keys[a] = keys[b];
      tags[a] = tags[b];
      keys[b] = k;
      tags[b] = t;
    endfunction

    function void apply_request(logic [FUNC_W-1:0] func, logic [KEY_W-1:0] key,
                                logic [TAG_W-1:0] tag);
      result_t r;
      int unsigned pos, parent, first, best, c;
      bit moving;
      r = '0;
      case (func)
        FUNC_ENQ: begin
          n_enq++;
          if (fill >= CAPACITY_DEF) begin
            r.status = ST_OVER;
            n_over++;
          end else begin
            keys[fill] = key;
            tags[fill] = tag;
            pos = fill;
            fill++;
            // climb while the parent is strictly larger
            moving = 1'b1;
            while (moving && pos > 0) begin
              parent = (pos - 1) / ARITY_DEF;
              if (keys[parent] > keys[pos]) begin
                swap_slots(parent, pos);
                pos = parent;
              end else begin
                moving = 1'b0;
              end
            end
          end
        end
        FUNC_DEQ, FUNC_PEEK: begin
          if (func == FUNC_DEQ) n_deq++;
          else n_peek++;
          if (fill == 0) begin
            r.status = ST_UNDER;
            n_under++;
          end else begin
            r.key = keys[0];
            r.tag = tags[0];
            r.valid = 1'b1;
            if (func == FUNC_DEQ) begin
              fill--;
              keys[0] = keys[fill];
              tags[0] = tags[fill];
              // sink toward the first strictly smallest child
              pos = 0;
              moving = 1'b1;
              while (moving) begin
                first = pos * ARITY_DEF + 1;
                if (first >= fill) begin
                  moving = 1'b0;
                end else begin
                  best = first;
                  for (int i = 2; i <= ARITY_DEF; i++) begin
                    c = pos * ARITY_DEF + i;
                    if (c < fill && keys[c] < keys[best]) best = c;
                  end
                  if (keys[pos] > keys[best]) begin
                    swap_slots(pos, best);
                    pos = best;
                  end else begin
                    moving = 1'b0;
                  end
                end
              end
            end
          end
        end
        default: n_nop++;
      endcase
      r.occupancy = fill[OCC_W-1:0];
      r.is_empty = (fill == 0);
      if (fill > peak_fill) peak_fill = fill;
      predicted_words.push_back(r);
    endfunction

    function void compare_field(string name, logic [KEY_W-1:0] exp_v, logic [KEY_W-1:0] got_v);
      if (exp_v !== got_v) begin
        $error("%s mismatch: expected 0x%0h, got 0x%0h", name, exp_v, got_v);
        errors++;
      end
    endfunction

    function void match_result(logic [63:0] tdata, logic [2:0] tuser);
      result_t exp_w;
      if (predicted_words.size() == 0) begin
        $error("result word with none pending: tdata 0x%0h tuser 0x%0h", tdata, tuser);
        errors++;
      end else begin
        exp_w = predicted_words.pop_front();
        compare_field("out_key", exp_w.key, tdata[31:0]);
        compare_field("out_tag", KEY_W'(exp_w.tag), KEY_W'(tdata[47:32]));
        compare_field("occupancy", KEY_W'(exp_w.occupancy), KEY_W'(tdata[56:48]));
        compare_field("is_empty", KEY_W'(exp_w.is_empty), KEY_W'(tdata[57]));
        compare_field("out_valid", KEY_W'(exp_w.valid), KEY_W'(tuser[0]));
        compare_field("status", KEY_W'(exp_w.status), KEY_W'(tuser[2:1]));
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [47:0] in_tdata;   // [31:0] key, [47:32] tag
  logic [1:0]  in_tuser;   // [1:0] func
  logic        out_tvalid;
  logic        out_tready;
  logic [63:0] out_tdata;  // [31:0] key, [47:32] tag, [56:48] occupancy, [57] is_empty
  logic [2:0]  out_tuser;  // [0] out_valid, [2:1] status

  heap_tracker mirror;
  bit idling;
  int stall_left;
  int unsigned quiet_cycles;

  d_ary_min_heap_queue_top DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  // 10 ns clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Stall the result side in random bursts; new bursts start only while idling is set
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      out_tready <= 1'b0;
    end else if (idling && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(0, 4);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // Check every accepted result word; watch for a hung handshake
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) mirror.match_result(out_tdata, out_tuser);
      if ((out_tvalid && out_tready) || (in_tvalid && in_tready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles == IDLE_LIMIT) begin
          $display("no handshake for %0d cycles", IDLE_LIMIT);
          $display("[d_ary_min_heap_queue_top] ERROR");
          $finish;
        end
      end
    end
  end

  // Offer one request word, with an optional gap first, and hold it until taken
  task automatic send_word(logic [FUNC_W-1:0] func, logic [KEY_W-1:0] key,
                           logic [TAG_W-1:0] tag);
    int gap;
    gap = (idling && $urandom_range(0, 4) == 0) ? $urandom_range(1, 5) : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= func;
    in_tdata <= {tag, key};
    do @(posedge clk); while (!in_tready);
    mirror.apply_request(func, key, tag);
  endtask

  // Stop sending until every pending result word has come back
  task automatic wait_drained();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (mirror.predicted_words.size() != 0) @(posedge clk);
  endtask

  function automatic logic [KEY_W-1:0] pick_key();
    case ($urandom_range(0, 3))
      0: pick_key = $urandom_range(0, 15);
      1: pick_key = $urandom;
      2: pick_key = $urandom_range(0, 1) ? '1 : '0;
      default: pick_key = $urandom_range(0, 1000);
    endcase
  endfunction

  // Random mix of operations; enq_pct sets how fast the heap grows
  task automatic run_mix(int count, int enq_pct);
    int r;
    for (int n = 0; n < count; n++) begin
      r = $urandom_range(0, 99);
      if (r < enq_pct) send_word(FUNC_ENQ, pick_key(), TAG_W'($urandom));
      else if (r < 88) send_word(FUNC_DEQ, $urandom, TAG_W'($urandom));
      else if (r < 97) send_word(FUNC_PEEK, $urandom, TAG_W'($urandom));
      else send_word(FUNC_NOP, $urandom, TAG_W'($urandom));
    end
  endtask

  initial begin
    mirror = new;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = FUNC_ENQ;
    out_tready = 1'b0;
    idling = 1'b1;
    stall_left = 0;
    quiet_cycles = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Empty heap: underflow on dequeue and peek, unused code
    send_word(FUNC_DEQ, 32'h0, 16'h0);
    send_word(FUNC_PEEK, '1, '1);
    send_word(FUNC_NOP, 32'hA5A5_5A5A, 16'h5AA5);
    // Extreme keys and tags, equal keys with different tags
    send_word(FUNC_ENQ, '1, '1);
    send_word(FUNC_PEEK, 32'h0, 16'h0);
    send_word(FUNC_ENQ, 32'h0, 16'h0);
    send_word(FUNC_ENQ, 32'd5, 16'd1);
    send_word(FUNC_ENQ, 32'd5, 16'd2);
    send_word(FUNC_ENQ, 32'd5, 16'd3);
    send_word(FUNC_NOP, '1, '1);
    send_word(FUNC_PEEK, 32'h1234_5678, 16'h9ABC);
    repeat (6) send_word(FUNC_DEQ, 32'h0, 16'h0);
    // Ties among children: first smallest child wins
    send_word(FUNC_ENQ, 32'd7, 16'd10);
    send_word(FUNC_ENQ, 32'd7, 16'd11);
    send_word(FUNC_ENQ, 32'd7, 16'd12);
    send_word(FUNC_ENQ, 32'd3, 16'd13);
    repeat (4) send_word(FUNC_DEQ, 32'h0, 16'h0);

    // Random traffic that grows the heap
    run_mix(560, 55);

    // Fill to capacity, then push past it
    while (mirror.fill < CAPACITY_DEF) begin
      if ($urandom_range(0, 9) == 0) send_word(FUNC_PEEK, $urandom, TAG_W'($urandom));
      else send_word(FUNC_ENQ, pick_key(), TAG_W'($urandom));
    end
    repeat (8) send_word(FUNC_ENQ, pick_key(), TAG_W'($urandom));
    wait_drained();
    send_word(FUNC_PEEK, $urandom, TAG_W'($urandom));

    // Drain to empty, then underflow again
    while (mirror.fill > 0) begin
      case ($urandom_range(0, 19))
        0: send_word(FUNC_ENQ, pick_key(), TAG_W'($urandom));
        1, 2: send_word(FUNC_PEEK, $urandom, TAG_W'($urandom));
        default: send_word(FUNC_DEQ, $urandom, TAG_W'($urandom));
      endcase
    end
    repeat (3) send_word(FUNC_DEQ, $urandom, TAG_W'($urandom));
    send_word(FUNC_PEEK, $urandom, TAG_W'($urandom));

    // Last stretch at full rate on both sides
    idling = 1'b0;
    run_mix(600, 52);

    @(negedge clk);
    in_tvalid <= 1'b0;
    while (mirror.predicted_words.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("ran %0d enqueues (%0d on a full heap), %0d dequeues, %0d peeks, %0d unused codes",
             mirror.n_enq, mirror.n_over, mirror.n_deq, mirror.n_peek, mirror.n_nop);
    $display("%0d requests hit an empty heap; deepest fill %0d of %0d",
             mirror.n_under, mirror.peak_fill, CAPACITY_DEF);
    if (mirror.errors == 0) begin
      $display("[d_ary_min_heap_queue_top] OK");
    end else begin
      $display("[d_ary_min_heap_queue_top] ERROR");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/dahq_pkg.sv
rtl/dahq_engine.sv
rtl/d_ary_min_heap_queue_top.sv
rtl/dahq_checker.sv
bench/testbench.sv
